/* src/sitc_pkg.sv */
// ----------------------------------------------------------------------------
// sitc_pkg - shared types and constants of the spiral index to grid cell unit
// Fixed widths of position, root and coordinates, and the record that moves
// down the square-root cell chain.
// ----------------------------------------------------------------------------
package sitc_pkg;

	localparam int POS_W   = 32;
	localparam int ROOT_W  = POS_W / 2;
	localparam int REM_W   = ROOT_W + 1;
	localparam int COORD_W = 16;

	// one query in flight along the chain
	typedef struct packed {
		logic               oor;     // position outside 1..side^2
		logic               one;     // position is the centre cell
		logic [POS_W-1:0]   pos;
		logic [COORD_W-1:0] mid;     // side/2 + 1, low bits only
		logic [POS_W-1:0]   digits;  // radicand digits not yet consumed, msb first
		logic [REM_W-1:0]   rem;     // partial remainder
		logic [ROOT_W-1:0]  root;    // partial root
	} cell_t;

endpackage

/* src/sitc_cell.sv */
// ----------------------------------------------------------------------------
// sitc_cell - one digit step of the integer square root chain
// Takes the next two radicand bits, decides one root bit and hands the
// updated record to the next cell on every clock.
// ----------------------------------------------------------------------------
module sitc_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  sitc_pkg::cell_t in_data,
	output logic           out_valid,
	output sitc_pkg::cell_t out_data
);
	import sitc_pkg::*;

	logic [REM_W+1:0] acc;
	logic [REM_W+1:0] trial;
	logic             take;
	cell_t            nxt;

	always_comb begin
		acc   = {in_data.rem, in_data.digits[POS_W-1 -: 2]};
		trial = {1'b0, in_data.root, 2'b01};
		take  = (acc >= trial);
		nxt   = in_data;
		nxt.digits = {in_data.digits[POS_W-3:0], 2'b00};
		if (take) begin
			nxt.rem  = REM_W'(acc - trial);
			nxt.root = {in_data.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem  = REM_W'(acc);
			nxt.root = {in_data.root[ROOT_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		out_data <= nxt;
	end

endmodule

/* src/sitc_ring_decode.sv */
// ----------------------------------------------------------------------------
// sitc_ring_decode - ring, side and offset to line and column
// From floor(sqrt(position-1)) finds the ring, its base square, the side
// of the ring and the step along it, then forms the cell coordinates.
// ----------------------------------------------------------------------------
module sitc_ring_decode (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  sitc_pkg::cell_t                in_data,
	output logic                           done,
	output logic [sitc_pkg::COORD_W-1:0]   line,
	output logic [sitc_pkg::COORD_W-1:0]   column,
	output logic                           out_of_range
);
	import sitc_pkg::*;

	localparam int D_W = ROOT_W + 2;

	localparam logic [1:0] SEG_TOP    = 2'd0;
	localparam logic [1:0] SEG_LEFT   = 2'd1;
	localparam logic [1:0] SEG_BOTTOM = 2'd2;
	localparam logic [1:0] SEG_RIGHT  = 2'd3;

	// stage 1: ring and base square
	logic [ROOT_W:0]    root_inc;
	logic [ROOT_W-1:0]  k_c;
	logic [ROOT_W-1:0]  odd_c;
	logic               valid_s1, oor_s1, one_s1;
	logic [POS_W-1:0]   pos_s1, base_s1;
	logic [COORD_W-1:0] mid_s1;
	logic [ROOT_W-1:0]  k_s1;

	assign root_inc = {1'b0, in_data.root} + (ROOT_W+1)'(1);
	assign k_c      = root_inc[ROOT_W:1];
	assign odd_c    = ROOT_W'({k_c, 1'b0} - (ROOT_W+1)'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		oor_s1  <= in_data.oor;
		one_s1  <= in_data.one;
		pos_s1  <= in_data.pos;
		mid_s1  <= in_data.mid;
		k_s1    <= k_c;
		base_s1 <= POS_W'(odd_c) * POS_W'(odd_c);
	end

	// stage 2: zero-based offset into the ring, below 8k
	logic [POS_W-1:0]   off_c;
	logic               valid_s2, oor_s2, one_s2;
	logic [D_W-1:0]     off_s2;
	logic [COORD_W-1:0] mid_s2;
	logic [ROOT_W-1:0]  k_s2;

	assign off_c = pos_s1 - base_s1 - POS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		oor_s2 <= oor_s1;
		one_s2 <= one_s1;
		off_s2 <= off_c[D_W-1:0];
		mid_s2 <= mid_s1;
		k_s2   <= k_s1;
	end

	// stage 3: side of the ring and step along it
	logic [D_W:0]       two_k, four_k, six_k;
	logic [D_W:0]       off_x;
	logic [1:0]         seg_c;
	logic [D_W:0]       step_c;
	logic               valid_s3, oor_s3, one_s3;
	logic [1:0]         seg_s3;
	logic [COORD_W-1:0] step_s3;
	logic [COORD_W-1:0] mid_s3;
	logic [COORD_W-1:0] k_s3;

	always_comb begin
		two_k  = (D_W+1)'({k_s2, 1'b0});
		four_k = (D_W+1)'({k_s2, 2'b00});
		six_k  = two_k + four_k;
		off_x  = (D_W+1)'(off_s2);
		if (off_x < two_k) begin
			seg_c  = SEG_TOP;
			step_c = off_x;
		end else if (off_x < four_k) begin
			seg_c  = SEG_LEFT;
			step_c = off_x - two_k;
		end else if (off_x < six_k) begin
			seg_c  = SEG_BOTTOM;
			step_c = off_x - four_k;
		end else begin
			seg_c  = SEG_RIGHT;
			step_c = off_x - six_k;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		oor_s3  <= oor_s2;
		one_s3  <= one_s2;
		seg_s3  <= seg_c;
		step_s3 <= step_c[COORD_W-1:0];
		mid_s3  <= mid_s2;
		k_s3    <= COORD_W'(k_s2);
	end

	// stage 4: offsets from the centre, modulo the coordinate width
	logic [COORD_W-1:0] dx, dy;
	logic [COORD_W-1:0] down_c, up_c, neg_k;

	always_comb begin
		down_c = k_s3 - COORD_W'(1) - step_s3;
		up_c   = step_s3 + COORD_W'(1) - k_s3;
		neg_k  = COORD_W'(0) - k_s3;
		case (seg_s3)
			SEG_TOP: begin
				dx = down_c;
				dy = k_s3;
			end
			SEG_LEFT: begin
				dx = neg_k;
				dy = down_c;
			end
			SEG_BOTTOM: begin
				dx = up_c;
				dy = neg_k;
			end
			default: begin
				dx = k_s3;
				dy = up_c;
			end
		endcase
		if (one_s3) begin
			dx = '0;
			dy = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		out_of_range <= oor_s3;
		if (oor_s3) begin
			line   <= '0;
			column <= '0;
		end else begin
			line   <= mid_s3 + dy;
			column <= mid_s3 + dx;
		end
	end

endmodule

/* src/spiral_index_to_grid_cell_unit.sv */
// ----------------------------------------------------------------------------
// spiral_index_to_grid_cell_unit - square spiral position to grid cell
// Maps a 1-based position along a centre-out square spiral onto the line and
// column of a grid of the given side.
// ----------------------------------------------------------------------------
// A query is taken on every clock that start is high; busy is always low.
// Each query gives exactly one result, shown for one cycle with done high,
// after the transfer passes one input stage holding the side squared,
// 16 square-root cells (one root bit each), and four ring decode stages.
// One query per cycle is sustained. The receiver cannot stall, so results
// must be captured on the cycle done is high.
module spiral_index_to_grid_cell_unit #(
	parameter int SIDE_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [SIDE_BITS-1:0]         grid_side,
	input  logic [sitc_pkg::POS_W-1:0]   position,
	output logic                         done,
	output logic [sitc_pkg::COORD_W-1:0] line,
	output logic [sitc_pkg::COORD_W-1:0] column,
	output logic                         out_of_range
);
	import sitc_pkg::*;

	localparam int SQ_W  = 2 * SIDE_BITS;
	localparam int CMP_W = (SQ_W > POS_W) ? SQ_W : POS_W;
	localparam int MID_W = (SIDE_BITS > COORD_W) ? SIDE_BITS : COORD_W;

	logic [MID_W-1:0]   mid_ext;
	logic               valid_s1;
	logic [POS_W-1:0]   pos_s1;
	logic [SQ_W-1:0]    sq_s1;
	logic [COORD_W-1:0] mid_s1;

	assign busy    = 1'b0;
	assign mid_ext = MID_W'(grid_side >> 1) + MID_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= position;
		sq_s1  <= SQ_W'(grid_side) * SQ_W'(grid_side);
		mid_s1 <= mid_ext[COORD_W-1:0];
	end

	cell_t chain_data  [0:ROOT_W];
	logic  chain_valid [0:ROOT_W];

	always_comb begin
		chain_valid[0]        = valid_s1;
		chain_data[0].oor     = (pos_s1 == '0) || (CMP_W'(pos_s1) > CMP_W'(sq_s1));
		chain_data[0].one     = (pos_s1 == POS_W'(1));
		chain_data[0].pos     = pos_s1;
		chain_data[0].mid     = mid_s1;
		chain_data[0].digits  = pos_s1 - POS_W'(1);
		chain_data[0].rem     = '0;
		chain_data[0].root    = '0;
	end

	for (genvar i = 0; i < ROOT_W; i++) begin : g_root
		sitc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_data   (chain_data[i]),
			.out_valid (chain_valid[i+1]),
			.out_data  (chain_data[i+1])
		);
	end

	sitc_ring_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (chain_valid[ROOT_W]),
		.in_data      (chain_data[ROOT_W]),
		.done         (done),
		.line         (line),
		.column       (column),
		.out_of_range (out_of_range)
	);

endmodule
